[rtl/ael_pkg.sv]
// Shared types and constants for the arithmetic expression lexer.
`default_nettype none

package ael_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned AEL_MAX_TEXT_LEN  = 65536;
	localparam int unsigned AEL_MANTISSA_BITS = 64;
	localparam int unsigned AEL_INT_LIMIT     = 2147483647;

	// Fixed field widths of the ports.
	localparam int unsigned KIND_W = 4;
	localparam int unsigned MANT_W = 64;
	localparam int unsigned FRAC_W = 6;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned POS_W  = 17;

	// Token kinds.
	localparam logic [KIND_W-1:0] K_INT     = 4'd0;
	localparam logic [KIND_W-1:0] K_FLOAT   = 4'd1;
	localparam logic [KIND_W-1:0] K_DOUBLE  = 4'd2;
	localparam logic [KIND_W-1:0] K_PLUS    = 4'd3;
	localparam logic [KIND_W-1:0] K_MINUS   = 4'd4;
	localparam logic [KIND_W-1:0] K_MULT    = 4'd5;
	localparam logic [KIND_W-1:0] K_DIV     = 4'd6;
	localparam logic [KIND_W-1:0] K_LPAREN  = 4'd7;
	localparam logic [KIND_W-1:0] K_RPAREN  = 4'd8;
	localparam logic [KIND_W-1:0] K_ILLEGAL = 4'd9;
	localparam logic [KIND_W-1:0] K_RANGE   = 4'd10;
	localparam logic [KIND_W-1:0] K_END     = 4'd11;

	// Request commands.
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Lexer modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_DROP = 2'd2;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LD     = 8'h64;
	localparam logic [CHAR_W-1:0] CH_UD     = 8'h44;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

	// Largest fraction digit count.
	localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd63;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MANT_W-1:0] mantissa;
		logic [FRAC_W-1:0] frac_digits;
		logic [CHAR_W-1:0] bad_char;
		logic [POS_W-1:0]  error_pos;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

[rtl/arith_expression_lexer_top.sv]
// Arithmetic expression lexer: input register, one-pass token logic, result queue.
// A request waits in the input register; its results are then written to the queue.
// Throughput: one request per cycle while the queue has room; a request that makes two
// results takes two entries of the four-entry result queue, which needs room for two.
// Reset: arst_n clears the mode, number state, text index and queue pointers at once;
// no clearing pass is needed.
`default_nettype none

module arith_expression_lexer_top #(
	parameter int unsigned MAX_TEXT_LEN  = ael_pkg::AEL_MAX_TEXT_LEN,
	parameter int unsigned MANTISSA_BITS = ael_pkg::AEL_MANTISSA_BITS,
	parameter int unsigned INT_LIMIT     = ael_pkg::AEL_INT_LIMIT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cmd,
	input  wire logic [ael_pkg::CHAR_W-1:0]  ch,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ael_pkg::KIND_W-1:0]       kind,
	output logic [ael_pkg::MANT_W-1:0]       mantissa,
	output logic [ael_pkg::FRAC_W-1:0]       frac_digits,
	output logic [ael_pkg::CHAR_W-1:0]       bad_char,
	output logic [ael_pkg::POS_W-1:0]        error_pos,
	output logic                             last
);
	import ael_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_TEXT_LEN + 1);
	localparam int unsigned EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int unsigned MB    = MANTISSA_BITS;
	localparam int unsigned PW    = MB + 4;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_TEXT_LEN);
	localparam logic [MB-1:0]    LIMIT   = MB'(INT_LIMIT);

	// Input register.
	logic              vld_s1;
	logic              cmd_s1;
	logic [CHAR_W-1:0] ch_s1;

	// Lexer state.
	logic [1:0]        mode_q;
	logic [MB-1:0]     dv_q;
	logic              dot_q;
	logic [FRAC_W-1:0] fc_q;
	logic              tl_q;
	logic [IDX_W-1:0]  idx_q;

	// Result queue.
	res_t       rq_q [4];
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic [2:0] cnt_q;

	// Next state and results of the current request.
	logic [1:0]        nxt_mode;
	logic [MB-1:0]     nxt_dv;
	logic              nxt_dot;
	logic [FRAC_W-1:0] nxt_fc;
	logic              nxt_tl;
	logic [IDX_W-1:0]  nxt_idx;
	logic [IDX_W-1:0]  idx_inc;
	logic              a_v;
	logic              b_v;
	res_t              a_res;
	res_t              b_res;
	res_t              w0_res;
	res_t              w1_res;
	logic [1:0]        npush;

	// Character classes and number closing.
	logic              is_digit;
	logic              is_ws;
	logic              is_sfx;
	logic              is_float_sfx;
	logic              tok_hit;
	logic [KIND_W-1:0] tok_kind;
	logic [3:0]        digit;
	logic [PW-1:0]     prod;
	logic              mul_ovf;
	logic              close_bad;
	logic [IDX_W-1:0]  close_pos;
	logic [EXT_W-1:0]  close_pos_x;
	logic [EXT_W-1:0]  cur_pos_x;
	res_t              idle_res;
	logic              idle_v;

	logic pop;
	logic room;
	logic fire;

	// Handshake and queue flow control.
	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q < 3'd3) || ((cnt_q == 3'd3) && pop);
	assign fire      = vld_s1 && room;
	assign in_stall  = vld_s1 && !room;

	// Head of the queue drives the result ports.
	assign kind        = rq_q[rd_q].kind;
	assign mantissa    = rq_q[rd_q].mantissa;
	assign frac_digits = rq_q[rd_q].frac_digits;
	assign bad_char    = rq_q[rd_q].bad_char;
	assign error_pos   = rq_q[rd_q].error_pos;
	assign last        = rq_q[rd_q].last;

	// Character classification and the mantissa times ten plus digit.
	always_comb begin
		is_digit     = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
		is_ws        = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB);
		is_float_sfx = (ch_s1 == CH_LF) || (ch_s1 == CH_UF);
		is_sfx       = is_float_sfx || (ch_s1 == CH_LD) || (ch_s1 == CH_UD);
		digit        = 4'(ch_s1 - CH_ZERO);
		tok_hit      = 1'b1;
		unique case (ch_s1)
			CH_PLUS:   tok_kind = K_PLUS;
			CH_MINUS:  tok_kind = K_MINUS;
			CH_STAR:   tok_kind = K_MULT;
			CH_SLASH:  tok_kind = K_DIV;
			CH_LPAREN: tok_kind = K_LPAREN;
			CH_RPAREN: tok_kind = K_RPAREN;
			default: begin
				tok_kind = K_ILLEGAL;
				tok_hit  = 1'b0;
			end
		endcase
		prod    = (PW'(dv_q) << 3) + (PW'(dv_q) << 1) + PW'(digit);
		mul_ovf = |prod[PW-1:MB];
		idx_inc = (idx_q == IDX_MAX) ? IDX_MAX : idx_q + 1'b1;
	end

	// Number close result and the idle-mode result for the current byte.
	always_comb begin
		close_bad   = tl_q || (!dot_q && (dv_q > LIMIT));
		close_pos   = (!cmd_s1 && is_sfx) ? idx_inc : idx_q;
		close_pos_x = EXT_W'(close_pos);
		cur_pos_x   = EXT_W'(idx_q);
		a_res       = '0;
		if (close_bad) begin
			a_res.kind      = K_RANGE;
			a_res.error_pos = close_pos_x[POS_W-1:0];
		end else begin
			a_res.mantissa = MANT_W'(dv_q);
			if (!dot_q) begin
				a_res.kind = K_INT;
			end else begin
				a_res.kind        = (!cmd_s1 && is_float_sfx) ? K_FLOAT : K_DOUBLE;
				a_res.frac_digits = fc_q;
			end
		end
		idle_res = '0;
		idle_v   = !is_ws && !is_digit;
		if (tok_hit) begin
			idle_res.kind = tok_kind;
		end else begin
			idle_res.kind      = K_ILLEGAL;
			idle_res.bad_char  = ch_s1;
			idle_res.error_pos = cur_pos_x[POS_W-1:0];
		end
	end

	// Lexer step: next state and up to two results.
	always_comb begin
		nxt_mode = mode_q;
		nxt_dv   = dv_q;
		nxt_dot  = dot_q;
		nxt_fc   = fc_q;
		nxt_tl   = tl_q;
		nxt_idx  = idx_inc;
		a_v      = 1'b0;
		b_v      = 1'b0;
		b_res    = idle_res;
		if (cmd_s1 == CMD_END) begin
			a_v        = (mode_q == MODE_NUM);
			b_v        = 1'b1;
			b_res      = '0;
			b_res.kind = K_END;
			nxt_mode   = MODE_IDLE;
			nxt_dv     = '0;
			nxt_dot    = 1'b0;
			nxt_fc     = '0;
			nxt_tl     = 1'b0;
			nxt_idx    = '0;
		end else begin
			unique case (mode_q)
				MODE_NUM: begin
					if (is_digit) begin
						// Append a digit unless the mantissa already overflowed.
						if (!tl_q) begin
							if (mul_ovf) begin
								nxt_tl = 1'b1;
							end else begin
								nxt_dv = prod[MB-1:0];
								if (dot_q) begin
									if (fc_q == FRAC_MAX) nxt_tl = 1'b1;
									else nxt_fc = fc_q + 1'b1;
								end
							end
						end
					end else if ((ch_s1 == CH_DOT) && !dot_q) begin
						nxt_dot = 1'b1;
					end else begin
						// Any other byte closes the number.
						a_v      = 1'b1;
						nxt_dv   = '0;
						nxt_dot  = 1'b0;
						nxt_fc   = '0;
						nxt_tl   = 1'b0;
						nxt_mode = close_bad ? MODE_DROP : MODE_IDLE;
						if (!is_sfx && !close_bad) begin
							b_v = idle_v;
							if (idle_v && !tok_hit) nxt_mode = MODE_DROP;
						end
					end
				end
				MODE_IDLE: begin
					if (is_digit) begin
						nxt_mode = MODE_NUM;
						nxt_dv   = MB'(digit);
						nxt_dot  = 1'b0;
						nxt_fc   = '0;
						nxt_tl   = 1'b0;
					end else begin
						b_v = idle_v;
						if (idle_v && !tok_hit) nxt_mode = MODE_DROP;
					end
				end
				default: begin
					nxt_mode = MODE_DROP;
				end
			endcase
		end
	end

	// Order the results for the queue and mark the final one.
	always_comb begin
		w0_res = a_v ? a_res : b_res;
		w1_res = b_res;
		npush  = 2'(a_v) + 2'(b_v);
		if (a_v && b_v) begin
			w1_res.last = 1'b1;
		end else begin
			w0_res.last = 1'b1;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd;
			ch_s1  <= ch;
		end
	end

	// Lexer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dv_q   <= '0;
			dot_q  <= 1'b0;
			fc_q   <= '0;
			tl_q   <= 1'b0;
			idx_q  <= '0;
		end else if (fire) begin
			mode_q <= nxt_mode;
			dv_q   <= nxt_dv;
			dot_q  <= nxt_dot;
			fc_q   <= nxt_fc;
			tl_q   <= nxt_tl;
			idx_q  <= nxt_idx;
		end
	end

	// Result queue pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 1'b1;
			if (fire) wr_q <= wr_q + npush;
			cnt_q <= cnt_q + (fire ? 3'(npush) : 3'd0) - 3'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (fire && (npush != 2'd0)) rq_q[wr_q] <= w0_res;
		if (fire && (npush == 2'd2)) rq_q[wr_q + 1'b1] <= w1_res;
	end

	// The queue never holds more than its four entries.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("result queue count exceeds depth");

	// End of text always returns the lexer to its reset state.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1 == CMD_END) |=> (mode_q == MODE_IDLE) && (idx_q == '0) && !tl_q)
		else $error("end of text did not reset the lexer");

	// Bytes in drop mode make no results.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1 == CMD_CHAR) && (mode_q == MODE_DROP) |-> (npush == 2'd0))
		else $error("result produced while dropping");

endmodule

`default_nettype wire

[test/arith_expression_lexer_top_tb.sv]
// Self-checking testbench for the arithmetic expression lexer top level.
`default_nettype none

module arith_expression_lexer_top_tb;
	import ael_pkg::*;

	localparam int unsigned RUN_LIMIT    = 100000;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 16;
	localparam int unsigned PHASE_ITEMS  = 300;

	// One request as the sender holds it.
	typedef struct packed {
		logic              cmd;
		logic [CHAR_W-1:0] ch;
	} lex_req_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              cmd       = CMD_CHAR;
	logic [CHAR_W-1:0] ch        = '0;
	logic              out_stall = 1'b0;
	wire logic              in_stall;
	wire logic              out_valid;
	wire logic [KIND_W-1:0] kind;
	wire logic [MANT_W-1:0] mantissa;
	wire logic [FRAC_W-1:0] frac_digits;
	wire logic [CHAR_W-1:0] bad_char;
	wire logic [POS_W-1:0]  error_pos;
	wire logic              last;

	arith_expression_lexer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.mantissa    (mantissa),
		.frac_digits (frac_digits),
		.bad_char    (bad_char),
		.error_pos   (error_pos),
		.last        (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	lex_req_t    pending_reqs[$];
	res_t        expected_tokens[$];
	int unsigned send_idle_pct  = 21;
	int unsigned recv_idle_pct  = 57;
	bit          long_hold_on   = 1'b0;
	int unsigned hold_count     = 0;
	int unsigned mismatch_count = 0;

	// Shadow lexer state.
	logic [1:0]        lx_mode  = MODE_IDLE;
	logic [MANT_W-1:0] lx_value = '0;
	logic              lx_dot   = 1'b0;
	int unsigned       lx_frac  = 0;
	logic              lx_big   = 1'b0;
	int unsigned       lx_index = 0;

	function automatic int unsigned sat_index(input int unsigned p);
		return (p > AEL_MAX_TEXT_LEN) ? AEL_MAX_TEXT_LEN : p;
	endfunction

	function automatic bit is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void emit_token(input logic [KIND_W-1:0] k, input logic [MANT_W-1:0] m,
			input int unsigned f, input logic [CHAR_W-1:0] b, input int unsigned p);
		res_t t;
		t.kind        = k;
		t.mantissa    = m;
		t.frac_digits = f[FRAC_W-1:0];
		t.bad_char    = b;
		t.error_pos   = p[POS_W-1:0];
		t.last        = 1'b0;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	function automatic void clear_number();
		lx_value = '0;
		lx_dot   = 1'b0;
		lx_frac  = 0;
		lx_big   = 1'b0;
	endfunction

	// Closes the open number; returns 1 when it turned into a range error.
	function automatic bit finish_number(input int unsigned p, input logic [CHAR_W-1:0] sfx);
		logic [KIND_W-1:0] k;
		bit                overflow;
		if (!lx_dot)
			k = K_INT;
		else if (sfx == CH_LF || sfx == CH_UF)
			k = K_FLOAT;
		else
			k = K_DOUBLE;
		overflow = lx_big || (!lx_dot && lx_value > MANT_W'(AEL_INT_LIMIT));
		if (overflow) begin
			emit_token(K_RANGE, '0, 0, '0, p);
			lx_mode = MODE_DROP;
		end else begin
			emit_token(k, lx_value, lx_dot ? lx_frac : 0, '0, 0);
			lx_mode = MODE_IDLE;
		end
		clear_number();
		return overflow;
	endfunction

	// Handles a byte seen outside a number.
	function automatic void start_byte(input logic [CHAR_W-1:0] c, input int unsigned p);
		if (c == CH_SPACE || c == CH_TAB)
			return;
		if (is_digit(c)) begin
			clear_number();
			lx_value = MANT_W'(c - CH_ZERO);
			lx_mode  = MODE_NUM;
			return;
		end
		case (c)
			CH_PLUS: begin
				emit_token(K_PLUS, '0, 0, '0, 0);
			end
			CH_MINUS: begin
				emit_token(K_MINUS, '0, 0, '0, 0);
			end
			CH_STAR: begin
				emit_token(K_MULT, '0, 0, '0, 0);
			end
			CH_SLASH: begin
				emit_token(K_DIV, '0, 0, '0, 0);
			end
			CH_LPAREN: begin
				emit_token(K_LPAREN, '0, 0, '0, 0);
			end
			CH_RPAREN: begin
				emit_token(K_RPAREN, '0, 0, '0, 0);
			end
			default: begin
				lx_mode = MODE_DROP;
				emit_token(K_ILLEGAL, '0, 0, c, p);
			end
		endcase
	endfunction

	// Appends one decimal digit, flagging mantissa or fraction overflow.
	function automatic void shift_digit(input logic [MANT_W-1:0] d);
		if (lx_big)
			return;
		if (lx_value > ({MANT_W{1'b1}} - d) / MANT_W'(10)) begin
			lx_big = 1'b1;
			return;
		end
		lx_value = lx_value * MANT_W'(10) + d;
		if (lx_dot) begin
			if (lx_frac >= FRAC_MAX)
				lx_big = 1'b1;
			else
				lx_frac++;
		end
	endfunction

	// Works out the tokens one accepted request causes.
	function automatic void predict_tokens(input logic c_cmd, input logic [CHAR_W-1:0] c);
		int unsigned p;
		int unsigned n0;
		res_t        t;
		p  = sat_index(lx_index);
		n0 = expected_tokens.size();
		if (c_cmd == CMD_END) begin
			if (lx_mode == MODE_NUM)
				void'(finish_number(p, '0));
			emit_token(K_END, '0, 0, '0, 0);
			lx_mode  = MODE_IDLE;
			clear_number();
			lx_index = 0;
		end else begin
			if (lx_mode == MODE_NUM) begin
				if (is_digit(c))
					shift_digit(MANT_W'(c - CH_ZERO));
				else if (c == CH_DOT && !lx_dot)
					lx_dot = 1'b1;
				else if (c == CH_LF || c == CH_UF || c == CH_LD || c == CH_UD)
					void'(finish_number(sat_index(p + 1), c));
				else if (!finish_number(p, '0))
					start_byte(c, p);
			end else if (lx_mode == MODE_IDLE) begin
				start_byte(c, p);
			end
			lx_index = sat_index(p + 1);
		end
		if (expected_tokens.size() > n0) begin
			t      = expected_tokens.pop_back();
			t.last = 1'b1;
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [MANT_W-1:0] got,
			input logic [MANT_W-1:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic check_token();
		res_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch("unexpected result kind", MANT_W'(kind), '0);
			return;
		end
		want = expected_tokens.pop_front();
		if (kind !== want.kind)
			report_mismatch("kind", MANT_W'(kind), MANT_W'(want.kind));
		if (mantissa !== want.mantissa)
			report_mismatch("mantissa", mantissa, want.mantissa);
		if (frac_digits !== want.frac_digits)
			report_mismatch("frac_digits", MANT_W'(frac_digits), MANT_W'(want.frac_digits));
		if (bad_char !== want.bad_char)
			report_mismatch("bad_char", MANT_W'(bad_char), MANT_W'(want.bad_char));
		if (error_pos !== want.error_pos)
			report_mismatch("error_pos", MANT_W'(error_pos), MANT_W'(want.error_pos));
		if (last !== want.last)
			report_mismatch("last", MANT_W'(last), MANT_W'(want.last));
	endtask

	// Sender: predicts each accepted request and offers the next pending one.
	always @(posedge clk) begin : drive_requests
		lex_req_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_tokens(cmd, ch);
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					cmd      <= next_req.cmd;
					ch       <= next_req.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks accepted results and stalls at random or for a long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid === 1'b1 && !out_stall)
				check_token();
			if (long_hold_on && hold_count < HOLD_CYCLES) begin
				hold_count++;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic add_byte(input logic [CHAR_W-1:0] c);
		lex_req_t r;
		r.cmd = CMD_CHAR;
		r.ch  = c;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// The byte of an end request carries random content that must be ignored.
	task automatic add_end();
		lex_req_t r;
		r.cmd = CMD_END;
		r.ch  = CHAR_W'($urandom_range(0, 255));
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_digits(input int unsigned count);
		repeat (count) add_byte(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
	endtask

	// A number of random shape, mostly plain values and sometimes aimed at the limits.
	task automatic add_number();
		int unsigned       style;
		logic [MANT_W-1:0] v;
		style = $urandom_range(0, 99);
		if (style < 50) begin
			add_digits($urandom_range(1, 4));
			if ($urandom_range(0, 1)) begin
				add_byte(CH_DOT);
				add_digits($urandom_range(0, 4));
			end
		end else if (style < 60) begin
			// Integers right around the signed 32-bit limit.
			v = MANT_W'(AEL_INT_LIMIT) - 1 + MANT_W'($urandom_range(0, 2));
			add_str($sformatf("%0d", v));
		end else if (style < 68) begin
			// Twenty significant digits, sometimes after a leading zero, straddling the top of the mantissa.
			v = {MANT_W{1'b1}} / MANT_W'(10);
			if ($urandom_range(0, 3) == 0)
				add_byte(CH_ZERO);
			add_str($sformatf("%0d", v));
			add_byte(CH_ZERO + CHAR_W'($urandom_range(4, 7)));
			if ($urandom_range(0, 1)) begin
				add_byte(CH_DOT);
				add_digits($urandom_range(0, 1));
			end
		end else if (style < 74) begin
			// Zero with a fraction count right around its limit.
			add_byte(CH_ZERO);
			add_byte(CH_DOT);
			repeat ($urandom_range(62, 64)) add_byte(CH_ZERO);
			if ($urandom_range(0, 1))
				add_digits(1);
		end else begin
			add_digits($urandom_range(1, 8));
			if ($urandom_range(0, 2) != 0) begin
				add_byte(CH_DOT);
				add_digits($urandom_range(0, 8));
			end
		end
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 3))
				0: add_byte(CH_LF);
				1: add_byte(CH_UF);
				2: add_byte(CH_LD);
				default: add_byte(CH_UD);
			endcase
		end
	endtask

	task automatic add_operator();
		case ($urandom_range(0, 5))
			0: add_byte(CH_PLUS);
			1: add_byte(CH_MINUS);
			2: add_byte(CH_STAR);
			3: add_byte(CH_SLASH);
			4: add_byte(CH_LPAREN);
			default: add_byte(CH_RPAREN);
		endcase
	endtask

	// One text: mostly well-formed tokens, some noise, usually closed by an end request.
	task automatic add_text();
		int unsigned pick;
		repeat ($urandom_range(1, 10)) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				add_number();
			end else if (pick < 70) begin
				add_operator();
			end else if (pick < 85) begin
				add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end else if (pick < 90) begin
				add_byte(CHAR_W'($urandom_range(0, 255)));
			end else if (pick < 93) begin
				add_byte(CH_DOT);
			end else begin
				// A number that runs into a second dot.
				add_digits($urandom_range(1, 3));
				add_byte(CH_DOT);
				add_digits($urandom_range(0, 2));
				add_byte(CH_DOT);
				add_digits($urandom_range(0, 2));
			end
		end
		if ($urandom_range(0, 99) < 95)
			add_end();
	endtask

	task automatic add_random_texts(input int unsigned count);
		int unsigned stop;
		stop = pending_reqs.size() + count;
		while (pending_reqs.size() < stop)
			add_text();
	endtask

	// Waits until every pending request is sent and every expected result has come.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(negedge clk);
	endtask

	// Run watchdog.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Phase sequencing.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every operator, a float suffix, a second dot, the byte extremes,
		// a lone dot and a number flushed by the end of text.
		add_str("7 +(3.5f-2)*4/1.2.");
		add_end();
		add_str("\t42");
		add_byte(8'hFF);
		add_end();
		add_str("6.");
		add_end();
		add_byte(8'h00);
		add_end();
		add_str(".");
		add_end();
		add_random_texts(PHASE_ITEMS);
		wait_drained();

		@(negedge clk);
		send_idle_pct = 57;
		recv_idle_pct = 21;
		add_random_texts(PHASE_ITEMS);
		wait_drained();

		// No idling; the receiver first holds off so the block backs up.
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_on  = 1'b1;
		add_random_texts(PHASE_ITEMS);

		// A float suffix followed by an illegal byte and a dropped digit.
		add_str("12.5f@9");
		add_end();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
